FILE: hw/rtl/multinomial_resample_select_unit_macros.svh
// assertion helpers shared by the rtl
`ifndef MULTINOMIAL_RESAMPLE_SELECT_UNIT_MACROS_SVH
`define MULTINOMIAL_RESAMPLE_SELECT_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle, checked out of reset
`define MRS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// property that holds at every clock edge out of reset
`define MRS_ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/mrs_pkg.sv
`timescale 1ns / 1ps

package mrs_pkg;

    localparam int DEF_MAX_PARTICLES = 1024;
    localparam int DEF_WEIGHT_BITS   = 32;
    localparam int DEF_DRAW_BITS     = 24;

    localparam int DEF_POS_W = $clog2(DEF_MAX_PARTICLES) + 1;
    localparam int DEF_CNT_W = $clog2(DEF_MAX_PARTICLES + 1);
    localparam int DEF_TOT_W = DEF_WEIGHT_BITS + $clog2(DEF_MAX_PARTICLES);
    localparam int DEF_THR_W = DEF_TOT_W + DEF_DRAW_BITS;

    // stream field layout
    localparam int OP_W            = 2;
    localparam int WEIGHT_FIELD_W  = 32;
    localparam int DRAW_FIELD_W    = 24;
    localparam int WEIGHT_LSB      = 0;
    localparam int DRAW_LSB        = WEIGHT_LSB + WEIGHT_FIELD_W;
    localparam int IN_DATA_W       = 56;
    localparam int IN_USER_W       = OP_W;
    localparam int IDX_FIELD_W     = 10;
    localparam int OUT_DATA_W      = 16;
    localparam int OUT_USER_W      = 1;
    localparam int COUNT_FIELD_W   = 11;

    // register port
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam int APB_ADDR_W = REG_IDX_W + 2;
    localparam logic [REG_IDX_W-1:0] REG_PARTICLE_COUNT = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_RESTART = 2'd0,
        OP_LOAD    = 2'd1,
        OP_DRAW    = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } state_t;

    typedef struct packed {
        logic                 valid;
        logic [DEF_POS_W-1:0] pos;
        logic [DEF_THR_W-1:0] thr;
        logic [DEF_CNT_W-1:0] n;
    } probe_tok_t;

    typedef struct packed {
        logic                 we;
        logic [DEF_POS_W-1:0] idx;
        logic [DEF_TOT_W-1:0] data;
    } ram_wr_t;

endpackage

FILE: hw/rtl/mrs_ram.sv
`timescale 1ns / 1ps

module mrs_ram #(
    parameter int WIDTH = mrs_pkg::DEF_TOT_W,
    parameter int DEPTH = mrs_pkg::DEF_MAX_PARTICLES
) (
    input  logic                                          clk,
    input  logic                                          we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
    input  logic [WIDTH-1:0]                              wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/mrs_scale.sv
`timescale 1ns / 1ps

module mrs_scale #(
    parameter int TOT_W  = mrs_pkg::DEF_TOT_W,
    parameter int DRAW_W = mrs_pkg::DEF_DRAW_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [TOT_W-1:0]        total,
    input  logic [DRAW_W-1:0]       draw,
    output logic                    thr_valid,
    output logic [TOT_W+DRAW_W-1:0] thr
);

    localparam int LO_W  = (TOT_W + 1) / 2;
    localparam int HI_W  = TOT_W - LO_W;
    localparam int THR_W = TOT_W + DRAW_W;

    logic                   valid_reg;
    logic [LO_W+DRAW_W-1:0] lo_reg, lo_next;
    logic [HI_W+DRAW_W-1:0] hi_reg, hi_next;

    // two half-width partial products
    assign lo_next = total[LO_W-1:0] * draw;
    assign hi_next = total[TOT_W-1:LO_W] * draw;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign thr_valid = valid_reg;
    assign thr       = (THR_W'(hi_reg) << LO_W) + THR_W'(lo_reg);

endmodule

FILE: hw/rtl/mrs_cell.sv
`timescale 1ns / 1ps

module mrs_cell #(
    parameter int  LEVEL         = 0,
    parameter int  MAX_PARTICLES = mrs_pkg::DEF_MAX_PARTICLES,
    parameter int  WEIGHT_BITS   = mrs_pkg::DEF_WEIGHT_BITS,
    parameter int  DRAW_BITS     = mrs_pkg::DEF_DRAW_BITS,
    parameter type tok_t         = mrs_pkg::probe_tok_t,
    parameter type wr_t          = mrs_pkg::ram_wr_t
) (
    input  logic clk,
    input  logic rst_n,
    input  wr_t  wr,
    input  tok_t tok_in,
    output tok_t tok_out
);

    localparam int POS_W = $clog2(MAX_PARTICLES) + 1;
    localparam int TOT_W = WEIGHT_BITS + $clog2(MAX_PARTICLES);
    localparam int DEPTH = ((MAX_PARTICLES - 1) >> (LEVEL + 1)) + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [POS_W-1:0] LOW_ONES  = POS_W'((1 << LEVEL) - 1);
    localparam logic [POS_W-1:0] SLOT_MASK = POS_W'((1 << (LEVEL + 1)) - 1);
    localparam logic [POS_W-1:0] STEP      = POS_W'(1 << LEVEL);

    tok_t             tok_reg, tok_next;
    logic             ram_we;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic [TOT_W-1:0] rdata;
    logic [POS_W-1:0] probe;
    logic             met;
    logic             hit;

    // this cell owns the entries whose index ends in exactly LEVEL ones
    assign ram_we = wr.we && ((wr.idx & SLOT_MASK) == LOW_ONES);
    assign waddr  = AW'(wr.idx >> (LEVEL + 1));
    assign raddr  = AW'(tok_in.pos >> (LEVEL + 1));

    mrs_ram #(
        .WIDTH (TOT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wr.data),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign tok_next = tok_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    // entries past the loaded span count as a hit
    assign probe = tok_reg.pos | LOW_ONES;
    assign met   = {rdata, {DRAW_BITS{1'b0}}} >= tok_reg.thr;
    assign hit   = (probe >= POS_W'(tok_reg.n)) || met;

    always_comb
    begin
        tok_out     = tok_reg;
        tok_out.pos = hit ? tok_reg.pos : (tok_reg.pos | STEP);
    end

endmodule

FILE: hw/rtl/multinomial_resample_select_unit.sv
// draw: the result reaches m_axis_tvalid through the scaling multiply register, the row of
//   clog2(MAX_PARTICLES)+1 cells and two result registers (pending, then output)
// load and restart: a new transaction accepted every cycle while idle; after a draw the
//   input waits until its result enters the output register, one draw in flight at a time
// reset: running total, load pointer and handshakes clear, particle_count returns to
//   MAX_PARTICLES; stored cumulative weights are not cleared and need no clearing pass
`timescale 1ns / 1ps
`include "multinomial_resample_select_unit_macros.svh"

module multinomial_resample_select_unit #(
    parameter int MAX_PARTICLES = mrs_pkg::DEF_MAX_PARTICLES,
    parameter int WEIGHT_BITS   = mrs_pkg::DEF_WEIGHT_BITS,
    parameter int DRAW_BITS     = mrs_pkg::DEF_DRAW_BITS
) (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [mrs_pkg::IN_DATA_W-1:0]   s_axis_tdata,   // weight, draw
    input  logic [mrs_pkg::IN_USER_W-1:0]   s_axis_tuser,   // op

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [mrs_pkg::OUT_DATA_W-1:0]  m_axis_tdata,   // particle_index
    output logic [mrs_pkg::OUT_USER_W-1:0]  m_axis_tuser,   // clamped

    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [mrs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [mrs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [mrs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int LOG_N  = $clog2(MAX_PARTICLES);
    localparam int POS_W  = LOG_N + 1;
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int TOT_W  = WEIGHT_BITS + LOG_N;
    localparam int THR_W  = TOT_W + DRAW_BITS;
    localparam int CREG_W = (CNT_W > mrs_pkg::COUNT_FIELD_W) ? CNT_W : mrs_pkg::COUNT_FIELD_W;
    localparam int IDX_W  = mrs_pkg::IDX_FIELD_W;

    typedef struct packed {
        logic             valid;
        logic [POS_W-1:0] pos;
        logic [THR_W-1:0] thr;
        logic [CNT_W-1:0] n;
    } tok_t;

    typedef struct packed {
        logic             we;
        logic [POS_W-1:0] idx;
        logic [TOT_W-1:0] data;
    } wr_t;

    mrs_pkg::state_t  state_reg, state_next;
    logic [TOT_W-1:0] total_reg, total_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CREG_W-1:0] count_reg, count_next;
    logic             out_valid_reg, out_valid_next;
    logic [IDX_W-1:0] out_index_reg, out_index_next;
    logic             out_clamped_reg, out_clamped_next;
    logic [IDX_W-1:0] pend_index_reg, pend_index_next;
    logic             pend_clamped_reg, pend_clamped_next;

    mrs_pkg::op_t       op;
    logic [WEIGHT_BITS-1:0] wt;
    logic [DRAW_BITS-1:0]   u;
    logic             in_ready;
    logic             in_acc;
    logic             draw_acc;
    logic             move;
    logic             cfg_we;
    logic [CNT_W-1:0] count_eff;
    logic [CNT_W-1:0] n_cur;
    logic             room;
    logic [TOT_W-1:0] load_sum;
    wr_t              wr;
    logic             thr_valid;
    logic [THR_W-1:0] thr;
    tok_t             chain [LOG_N+2];
    logic [LOG_N+1:0] chain_valid;
    logic [POS_W-1:0] res_pos;
    logic             res_clamped;

    assign op       = mrs_pkg::op_t'(s_axis_tuser);
    assign wt       = WEIGHT_BITS'(s_axis_tdata[mrs_pkg::WEIGHT_LSB +: mrs_pkg::WEIGHT_FIELD_W]);
    assign u        = DRAW_BITS'(s_axis_tdata[mrs_pkg::DRAW_LSB +: mrs_pkg::DRAW_FIELD_W]);
    assign in_acc   = s_axis_tvalid && in_ready;
    assign draw_acc = in_acc && (op == mrs_pkg::OP_DRAW);

    // register port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr[mrs_pkg::APB_ADDR_W-1:2] == mrs_pkg::REG_PARTICLE_COUNT);
    assign prdata = (paddr[mrs_pkg::APB_ADDR_W-1:2] == mrs_pkg::REG_PARTICLE_COUNT)
                    ? mrs_pkg::APB_DATA_W'(count_reg) : '0;
    assign count_next = cfg_we ? CREG_W'(pwdata[mrs_pkg::COUNT_FIELD_W-1:0]) : count_reg;

    always_comb
    begin
        priority if (count_reg == '0)
        begin
            count_eff = CNT_W'(1);
        end
        else if (32'(count_reg) > 32'(MAX_PARTICLES))
        begin
            count_eff = CNT_W'(MAX_PARTICLES);
        end
        else
        begin
            count_eff = CNT_W'(count_reg);
        end
    end

    assign n_cur    = (ptr_reg < count_eff) ? ptr_reg : count_eff;
    assign room     = ptr_reg < count_eff;
    assign load_sum = total_reg + TOT_W'(wt);

    // running total and load pointer
    always_comb
    begin
        total_next = total_reg;
        ptr_next   = ptr_reg;
        if (in_acc)
        begin
            unique case (op)
                mrs_pkg::OP_RESTART:
                begin
                    total_next = '0;
                    ptr_next   = '0;
                end
                mrs_pkg::OP_LOAD:
                begin
                    if (room)
                    begin
                        total_next = load_sum;
                        ptr_next   = ptr_reg + CNT_W'(1);
                    end
                end
                mrs_pkg::OP_DRAW:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        wr.we   = in_acc && (op == mrs_pkg::OP_LOAD) && room;
        wr.idx  = POS_W'(ptr_reg);
        wr.data = load_sum;
    end

    mrs_scale #(
        .TOT_W  (TOT_W),
        .DRAW_W (DRAW_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (draw_acc),
        .total     (total_reg),
        .draw      (u),
        .thr_valid (thr_valid),
        .thr       (thr)
    );

    always_comb
    begin
        chain[0].valid = thr_valid;
        chain[0].pos   = '0;
        chain[0].thr   = thr;
        chain[0].n     = n_cur;
    end

    assign chain_valid[0] = chain[0].valid;

    // one cell per index bit, top bit first
    for (genvar k = 0; k <= LOG_N; k++)
    begin : g_cell
        mrs_cell #(
            .LEVEL         (LOG_N - k),
            .MAX_PARTICLES (MAX_PARTICLES),
            .WEIGHT_BITS   (WEIGHT_BITS),
            .DRAW_BITS     (DRAW_BITS),
            .tok_t         (tok_t),
            .wr_t          (wr_t)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (chain[k]),
            .tok_out (chain[k+1])
        );

        assign chain_valid[k+1] = chain[k+1].valid;
    end

    assign res_pos     = chain[LOG_N+1].pos;
    assign res_clamped = res_pos >= POS_W'(chain[LOG_N+1].n);

    always_comb
    begin
        pend_index_next   = pend_index_reg;
        pend_clamped_next = pend_clamped_reg;
        if (chain[LOG_N+1].valid)
        begin
            pend_clamped_next = res_clamped;
            pend_index_next   = res_clamped ? IDX_W'(count_eff - CNT_W'(1)) : IDX_W'(res_pos);
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mrs_pkg::ST_IDLE:
            begin
                if (draw_acc)
                begin
                    state_next = mrs_pkg::ST_SEARCH;
                end
            end
            mrs_pkg::ST_SEARCH:
            begin
                if (chain[LOG_N+1].valid)
                begin
                    state_next = mrs_pkg::ST_DRAIN;
                end
            end
            mrs_pkg::ST_DRAIN:
            begin
                if (move)
                begin
                    state_next = mrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mrs_pkg::ST_IDLE;
            end
        endcase
    end

    // state outputs
    always_comb
    begin
        in_ready = 1'b0;
        move     = 1'b0;
        unique case (state_reg)
            mrs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
            end
            mrs_pkg::ST_SEARCH:
            begin
            end
            mrs_pkg::ST_DRAIN:
            begin
                move = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg;
        out_index_next   = out_index_reg;
        out_clamped_next = out_clamped_reg;
        if (move)
        begin
            out_valid_next   = 1'b1;
            out_index_next   = pend_index_reg;
            out_clamped_next = pend_clamped_reg;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mrs_pkg::ST_IDLE;
            total_reg     <= '0;
            ptr_reg       <= '0;
            count_reg     <= CREG_W'(MAX_PARTICLES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            total_reg     <= total_next;
            ptr_reg       <= ptr_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_index_reg    <= out_index_next;
        out_clamped_reg  <= out_clamped_next;
        pend_index_reg   <= pend_index_next;
        pend_clamped_reg <= pend_clamped_next;
    end

    assign s_axis_tready = in_ready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mrs_pkg::OUT_DATA_W'(out_index_reg);
    assign m_axis_tuser  = out_clamped_reg;

    `MRS_ASSERT_IMP(a_launch_after_draw, clk, rst_n, chain[0].valid, $past(draw_acc), "search launched without a draw transaction")
    `MRS_ASSERT_IMP(a_result_in_search, clk, rst_n, chain[LOG_N+1].valid, state_reg == mrs_pkg::ST_SEARCH, "search result outside search state")
    `MRS_ASSERT_ALWAYS(a_single_token, clk, rst_n, $onehot0(chain_valid), "more than one draw in the cell row")
    `MRS_ASSERT_IMP(a_clamp_index, clk, rst_n, out_valid_reg && out_clamped_reg, out_index_reg == IDX_W'(count_eff - CNT_W'(1)), "clamped result not at last particle")

endmodule
